[sv/tarag_pkg.sv]
// ----------------------------------------------------------------------------
// tarag_pkg: shared types and constants for the reverse address generator
// Token format handed from cell to cell, FSM states, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package tarag_pkg;

    localparam int MAX_DIMS      = 8;
    localparam int DIM_BITS      = 16;
    localparam int INDEX_BITS    = 40;
    localparam int NDIM_BITS     = 4;
    localparam int SIZE_FIELD    = 16;
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 64;
    localparam int TDATA_IN_BITS = 8;
    localparam int TDATA_BITS    = ((2 * INDEX_BITS + 7) / 8) * 8;
    localparam int TUSER_BITS    = 2;

    // running element count times one size
    localparam int PROD_BITS = INDEX_BITS + 1 + DIM_BITS;
    localparam logic [PROD_BITS-1:0] COUNT_LIMIT = PROD_BITS'(1) << INDEX_BITS;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_NUM_DIMS   = 2'd0;
    localparam logic [1:0] REG_REV_MASK   = 2'd1;
    localparam logic [1:0] REG_SIZES_LOW  = 2'd2;
    localparam logic [1:0] REG_SIZES_HIGH = 2'd3;

    localparam logic [APB_DATA_BITS-1:0] SIZES_RESET = 64'h0001_0001_0001_0001;

    typedef enum logic [1:0] {
        TK_SETUP,   // latch sizes, build strides and element count
        TK_FIRST,   // zero counters, sum spans of reversed dims
        TK_STEP     // odometer increment, accumulate source delta
    } t_tok_kind;

    typedef struct packed {
        logic                  valid;
        t_tok_kind             kind;
        logic [INDEX_BITS:0]   prod;
        logic                  over;
        logic                  zero;
        logic [INDEX_BITS-1:0] acc;
        logic                  carry;
        logic                  at_end;
    } t_tok;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[sv/tensor_axis_reverse_address_gen.sv]
// ----------------------------------------------------------------------------
// tensor_axis_reverse_address_gen: copy addresses for axis-reversing a tensor
// Walks a row-major tensor of 1..8 dims and issues dst/src element indices.
//
// Usage:
//   s_axis: one request word, tdata[0] = restart. restart=1 latches sizes and
//     reverse mask and returns element zero; restart=0 returns the next one.
//     An advance with no walk in progress is taken and returns nothing.
//   m_axis: one result word per restart or walk advance. tdata = src_index, dst_index;
//     tlast marks the final element; tuser = empty_res, error.
//   APB: 64-bit registers at 8*i (num_dims, reverse_mask, sizes_low,
//     sizes_high). Write only between requests; sizes apply at restart.
// Timing:
//   A token ripples through a row of eight dimension cells, one cell a cycle,
//   innermost dim first. An advance takes one pass to the result. A restart
//   takes two passes (strides/count, then first source index), or only the
//   first for an empty or oversized shape; bad num_dims skips the cell row.
//   One request is in flight at a time; s_axis_tready is high only when idle.
//   The result sits in an output register, so the next request is accepted
//   while m_axis is stalled; that request then waits for the register.
// Reset: synchronous, active low. Registers return to 1 dim, no reversal,
//   all sizes 1; no walk in progress, m_axis_tvalid low.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_axis_reverse_address_gen
    import tarag_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request stream
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [TDATA_IN_BITS-1:0] s_axis_tdata,   // [0] restart
    // result stream
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [TDATA_BITS-1:0]         m_axis_tdata,   // [39:0] src_index, [79:40] dst_index
    output logic                          m_axis_tlast,   // last element
    output logic [TUSER_BITS-1:0]         m_axis_tuser,   // [0] empty_res, [1] error
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    // ---------------- configuration registers ----------------
    logic [NDIM_BITS-1:0]     r_num_dims;
    logic [MAX_DIMS-1:0]      r_rev_mask;
    logic [APB_DATA_BITS-1:0] r_sizes_low;
    logic [APB_DATA_BITS-1:0] r_sizes_high;
    logic [1:0]               w_reg_idx;
    logic                     w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims   <= NDIM_BITS'(1);
            r_rev_mask   <= '0;
            r_sizes_low  <= SIZES_RESET;
            r_sizes_high <= SIZES_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_NUM_DIMS:   r_num_dims   <= pwdata[NDIM_BITS-1:0];
                REG_REV_MASK:   r_rev_mask   <= pwdata[MAX_DIMS-1:0];
                REG_SIZES_LOW:  r_sizes_low  <= pwdata;
                REG_SIZES_HIGH: r_sizes_high <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_NUM_DIMS:   prdata = APB_DATA_BITS'(r_num_dims);
            REG_REV_MASK:   prdata = APB_DATA_BITS'(r_rev_mask);
            REG_SIZES_LOW:  prdata = r_sizes_low;
            REG_SIZES_HIGH: prdata = r_sizes_high;
        endcase
    end

    // ---------------- cell row ----------------
    // w_tok[MAX_DIMS] enters the innermost cell; w_tok[0] leaves the outermost
    t_tok                    w_tok [MAX_DIMS+1];
    t_tok                    w_tok_in;
    logic [2*APB_DATA_BITS-1:0] w_sizes_all;
    logic [DIM_BITS-1:0]     w_size [MAX_DIMS];

    assign w_sizes_all     = {r_sizes_high, r_sizes_low};
    assign w_tok[MAX_DIMS] = w_tok_in;

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
        // unused dims count as size 1
        assign w_size[k] = (NDIM_BITS'(k) < r_num_dims) ?
                           w_sizes_all[k*SIZE_FIELD +: DIM_BITS] : DIM_BITS'(1);

        tarag_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[k+1]),
            .i_size  (w_size[k]),
            .i_rev   (r_rev_mask[k]),
            .o_tok   (w_tok[k])
        );
    end

    // ---------------- sequencer ----------------
    t_state                r_state;
    t_state                n_state;
    logic [INDEX_BITS-1:0] r_src;
    logic [INDEX_BITS-1:0] r_dst;
    logic                  r_walk_done;
    logic                  r_res_last;
    logic                  r_res_empty;
    logic                  r_res_err;

    logic                  w_in_acc;
    logic                  w_restart;
    logic                  w_bad_dims;
    logic                  w_out_free;
    logic                  w_tok_back;
    logic                  w_flag;
    logic                  w_flag_empty;
    logic                  w_take_walk;
    logic                  w_load_out;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_restart  = s_axis_tdata[0];
    assign w_bad_dims = (r_num_dims == '0) || (r_num_dims > NDIM_BITS'(MAX_DIMS));
    assign w_out_free = !m_axis_tvalid || m_axis_tready;
    assign w_tok_back = w_tok[0].valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_restart) begin
                        n_state = w_bad_dims ? ST_EMIT : ST_SETUP;
                    end else if (!r_walk_done) begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_SETUP: begin
                if (w_tok_back) begin
                    n_state = (w_tok[0].zero || w_tok[0].over) ? ST_EMIT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_tok_back) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready     = 1'b0;
        w_tok_in          = '0;
        w_flag            = 1'b0;
        w_flag_empty      = 1'b0;
        w_take_walk       = 1'b0;
        w_load_out        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_acc && w_restart) begin
                    if (w_bad_dims) begin
                        w_flag = 1'b1;
                    end else begin
                        w_tok_in.valid = 1'b1;
                        w_tok_in.kind  = TK_SETUP;
                        w_tok_in.prod  = (INDEX_BITS+1)'(1);
                    end
                end else if (w_in_acc && !r_walk_done) begin
                    w_tok_in.valid  = 1'b1;
                    w_tok_in.kind   = TK_STEP;
                    w_tok_in.acc    = r_src;
                    w_tok_in.carry  = 1'b1;
                    w_tok_in.at_end = 1'b1;
                end
            end
            ST_SETUP: begin
                if (w_tok_back) begin
                    if (w_tok[0].zero) begin
                        w_flag       = 1'b1;
                        w_flag_empty = 1'b1;
                    end else if (w_tok[0].over) begin
                        w_flag = 1'b1;
                    end else begin
                        w_tok_in.valid  = 1'b1;
                        w_tok_in.kind   = TK_FIRST;
                        w_tok_in.at_end = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                w_take_walk = w_tok_back;
            end
            ST_EMIT: begin
                w_load_out = w_out_free;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walk_done <= 1'b1;
            r_src       <= '0;
            r_dst       <= '0;
        end else begin
            r_state <= n_state;
            if (w_flag) begin
                // empty tensor or bad shape: walk ends, indices read zero
                r_walk_done <= 1'b1;
                r_src       <= '0;
                r_dst       <= '0;
            end else if (w_take_walk) begin
                r_walk_done <= w_tok[0].at_end;
                r_src       <= w_tok[0].acc;
                r_dst       <= (w_tok[0].kind == TK_FIRST) ? '0 : (r_dst + INDEX_BITS'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flag) begin
            r_res_last  <= 1'b0;
            r_res_empty <= w_flag_empty;
            r_res_err   <= ~w_flag_empty;
        end else if (w_take_walk) begin
            r_res_last  <= w_tok[0].at_end;
            r_res_empty <= 1'b0;
            r_res_err   <= 1'b0;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_load_out) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            m_axis_tdata <= TDATA_BITS'({r_dst, r_src});
            m_axis_tlast <= r_res_last;
            m_axis_tuser <= {r_res_err, r_res_empty};
        end
    end

endmodule

`default_nettype wire

[sv/tarag_cell.sv]
// ----------------------------------------------------------------------------
// tarag_cell: one dimension of the address walk
// Holds counter, size, stride and span of its dimension; acts on the token
// arriving from the inner neighbor and passes it outward, registered, in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tarag_cell
    import tarag_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_tok                i_tok,
    input  wire logic [DIM_BITS-1:0] i_size,
    input  wire logic                i_rev,
    output t_tok                     o_tok
);

    t_tok                  r_tok;
    t_tok                  n_tok;
    logic [DIM_BITS-1:0]   r_cnt;
    logic [DIM_BITS-1:0]   n_cnt;
    logic [DIM_BITS-1:0]   r_size;
    logic                  r_rev;
    logic [INDEX_BITS-1:0] r_stride;
    logic [INDEX_BITS-1:0] r_span;
    logic                  r_span_pend;

    logic [PROD_BITS-1:0]  w_full;
    logic [DIM_BITS-1:0]   w_last;
    logic                  w_wrap;
    logic [INDEX_BITS-1:0] w_delta;
    logic                  w_sub;

    assign w_full = {{DIM_BITS{1'b0}}, i_tok.prod} * {{(INDEX_BITS+1){1'b0}}, i_size};
    assign w_last = r_size - DIM_BITS'(1);
    assign w_wrap = (r_cnt == w_last);

    always_comb begin
        n_tok   = i_tok;
        n_cnt   = r_cnt;
        w_delta = '0;
        w_sub   = 1'b0;
        case (i_tok.kind)
            TK_SETUP: begin
                n_tok.prod = w_full[INDEX_BITS:0];
                n_tok.over = i_tok.over | (w_full > COUNT_LIMIT);
                n_tok.zero = i_tok.zero | (i_size == '0);
            end
            TK_FIRST: begin
                n_cnt        = '0;
                w_delta      = r_rev ? r_span : '0;
                n_tok.at_end = i_tok.at_end & (w_last == '0);
            end
            TK_STEP: begin
                if (i_tok.carry) begin
                    if (w_wrap) begin
                        // wrap: reversed index jumps back up by the span, forward index drops back by it
                        n_cnt       = '0;
                        w_delta     = r_span;
                        w_sub       = ~r_rev;
                        n_tok.carry = 1'b1;
                    end else begin
                        n_cnt       = r_cnt + DIM_BITS'(1);
                        w_delta     = r_stride;
                        w_sub       = r_rev;
                        n_tok.carry = 1'b0;
                    end
                end
                n_tok.at_end = i_tok.at_end & (n_cnt == w_last);
            end
            default: ;
        endcase
        n_tok.acc = w_sub ? (i_tok.acc - w_delta) : (i_tok.acc + w_delta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok       <= '0;
            r_cnt       <= '0;
            r_span_pend <= 1'b0;
        end else begin
            r_tok       <= n_tok;
            r_span_pend <= i_tok.valid && (i_tok.kind == TK_SETUP);
            if (i_tok.valid) begin
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && (i_tok.kind == TK_SETUP)) begin
            r_size   <= i_size;
            r_rev    <= i_rev;
            r_stride <= i_tok.prod[INDEX_BITS-1:0];
        end
        // span = (size-1)*stride, from the product still in the output stage
        if (r_span_pend) begin
            r_span <= r_tok.prod[INDEX_BITS-1:0] - r_stride;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[sv/tarag_checker.sv]
// ----------------------------------------------------------------------------
// tarag_checker: port-level checks for the reverse address generator
// Bound to the top level; watches the result stream only.
// ----------------------------------------------------------------------------
`default_nettype none

module tarag_checker
    import tarag_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [TDATA_BITS-1:0] m_axis_tdata,
    input wire logic                  m_axis_tlast,
    input wire logic [TUSER_BITS-1:0] m_axis_tuser
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // empty and error are exclusive
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("empty and error both set");

    // flagged result carries zero indices and no last
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) |->
            (m_axis_tdata == '0) && !m_axis_tlast)
        else $error("flagged result with indices or last");

endmodule

bind tensor_axis_reverse_address_gen tarag_checker u_tarag_checker (.*);

`default_nettype wire
